### design/lgts_pkg.sv
// Shared types, constants and codes of the LDA topic sampler.
`default_nettype none
package lgts_pkg;

   localparam int MAX_TOPICS  = 64;
   localparam int MAX_GENES   = 4096;
   localparam int MAX_SAMPLES = 256;
   localparam int MAX_TOKENS  = 1048576;

   localparam int TOPIC_W  = $clog2(MAX_TOPICS);
   localparam int GENE_W   = $clog2(MAX_GENES);
   localparam int SAMPLE_W = $clog2(MAX_SAMPLES);
   localparam int TOKEN_W  = $clog2(MAX_TOKENS);
   localparam int TCNT_W   = TOPIC_W + 1;        // holds the topic count itself
   localparam int CNT_W    = 21;
   localparam int Q_W      = 32;                 // Q16.16 operand width
   localparam int NG_W     = 13;
   localparam int W_W      = 48;                 // weight width
   localparam int SUM_W    = W_W + TOPIC_W;      // sum of all weights
   localparam int NUM_W    = CNT_W + 16 + 1;     // Q22.16 numerator and sample term
   localparam int DVD_W    = NUM_W + 16;         // dividend
   localparam int GB_W     = NG_W + Q_W;         // genes * beta
   localparam int DEN_W    = GB_W + 1;
   localparam int DSH_W    = DEN_W + Q_W;        // divisor aligned to the top quotient bit
   localparam int DIV_STEPS = Q_W + 1;           // saturation check plus one per bit
   localparam int STEP_W   = $clog2(DIV_STEPS);
   localparam int GADDR_W  = GENE_W + TOPIC_W;
   localparam int SADDR_W  = SAMPLE_W + TOPIC_W;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // request field layout
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 96;

   // func codes
   typedef enum logic [1:0] {
      FUNC_ASSIGN   = 2'd0,
      FUNC_RESAMPLE = 2'd1,
      FUNC_QUERY    = 2'd2,
      FUNC_NONE     = 2'd3
   } lgts_func_type;

   // register indexes
   localparam logic [1:0] REG_NUM_TOPICS = 2'd0;
   localparam logic [1:0] REG_NUM_GENES  = 2'd1;
   localparam logic [1:0] REG_ALPHA      = 2'd2;
   localparam logic [1:0] REG_BETA       = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_TOK_WAIT, ST_TOK_TAKE, ST_REM_RD, ST_REM_WR,
      ST_W_RD, ST_W_START, ST_W_DIV, ST_W_MLO, ST_W_MHI, ST_W_ACC,
      ST_R_MUL, ST_R_FIN, ST_K_RD, ST_K_CMP, ST_ADD_RD, ST_ADD_WR, ST_F_RD, ST_OUT
   } lgts_state_type;

   // controller to datapath
   typedef struct packed {
      logic               load;
      logic               clr;
      logic               tok_take;
      logic               init_topic;
      logic               tok_wr;
      logic               cnt_wr;
      logic               cnt_inc;
      logic               sel_j;
      logic               w_start;
      logic               div_step;
      logic               div_first;
      logic               mul_lo;
      logic               mul_hi;
      logic               acc;
      logic               r_mul;
      logic               r_fin;
      logic               walk;
      logic               walk_last;
      logic               out_load;
      logic [TOPIC_W-1:0] j;
   } lgts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic walk_hit;
      logic out_busy;
   } lgts_stat_type;

endpackage
`default_nettype wire

### design/lgts_ctrl.sv
// Sequencer of the topic sampler: walks assign, resample and query steps.
`default_nettype none
module lgts_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [1:0]                   req_tuser,
   input  wire logic [lgts_pkg::TCNT_W-1:0]  t_used,
   input  wire lgts_pkg::lgts_stat_type      stat,
   output lgts_pkg::lgts_cmd_type            cmd
);

   lgts_pkg::lgts_state_type state_ff, state_in;
   logic [lgts_pkg::TCNT_W-1:0] j_ff, j_in;
   logic [lgts_pkg::STEP_W-1:0] k_ff, k_in;
   logic                        j_last;

   assign j_last = (j_ff == t_used - lgts_pkg::TCNT_W'(1));

   // state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgts_pkg::ST_CLEAR;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      cmd        = '0;
      cmd.j      = j_ff[lgts_pkg::TOPIC_W-1:0];
      req_tready = 1'b0;
      unique case (state_ff)
         lgts_pkg::ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) state_in = lgts_pkg::ST_IDLE;
         end
         lgts_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            j_in       = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (lgts_pkg::lgts_func_type'(req_tuser))
                  lgts_pkg::FUNC_ASSIGN:   state_in = lgts_pkg::ST_INIT;
                  lgts_pkg::FUNC_RESAMPLE: state_in = lgts_pkg::ST_TOK_WAIT;
                  lgts_pkg::FUNC_QUERY:    state_in = lgts_pkg::ST_F_RD;
                  lgts_pkg::FUNC_NONE:     state_in = lgts_pkg::ST_IDLE;
               endcase
            end
         end
         lgts_pkg::ST_INIT: begin
            cmd.init_topic = 1'b1;
            state_in       = lgts_pkg::ST_ADD_RD;
         end
         lgts_pkg::ST_TOK_WAIT: state_in = lgts_pkg::ST_TOK_TAKE;
         lgts_pkg::ST_TOK_TAKE: begin
            cmd.tok_take = 1'b1;
            state_in     = lgts_pkg::ST_REM_RD;
         end
         lgts_pkg::ST_REM_RD: state_in = lgts_pkg::ST_REM_WR;
         lgts_pkg::ST_REM_WR: begin
            cmd.cnt_wr = 1'b1;
            state_in   = lgts_pkg::ST_W_RD;
         end
         // per-topic weight: read counts, divide, two multiplies, accumulate
         lgts_pkg::ST_W_RD: begin
            cmd.sel_j = 1'b1;
            state_in  = lgts_pkg::ST_W_START;
         end
         lgts_pkg::ST_W_START: begin
            cmd.w_start = 1'b1;
            k_in        = '0;
            state_in    = lgts_pkg::ST_W_DIV;
         end
         lgts_pkg::ST_W_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (k_ff == '0);
            k_in          = k_ff + lgts_pkg::STEP_W'(1);
            if (k_ff == lgts_pkg::STEP_W'(lgts_pkg::DIV_STEPS - 1))
               state_in = lgts_pkg::ST_W_MLO;
         end
         lgts_pkg::ST_W_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = lgts_pkg::ST_W_MHI;
         end
         lgts_pkg::ST_W_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = lgts_pkg::ST_W_ACC;
         end
         lgts_pkg::ST_W_ACC: begin
            cmd.acc = 1'b1;
            if (j_last) begin
               j_in     = '0;
               state_in = lgts_pkg::ST_R_MUL;
            end else begin
               j_in     = j_ff + lgts_pkg::TCNT_W'(1);
               state_in = lgts_pkg::ST_W_RD;
            end
         end
         lgts_pkg::ST_R_MUL: begin
            cmd.r_mul = 1'b1;
            state_in  = lgts_pkg::ST_R_FIN;
         end
         lgts_pkg::ST_R_FIN: begin
            cmd.r_fin = 1'b1;
            state_in  = lgts_pkg::ST_K_RD;
         end
         // cumulative walk over stored weights
         lgts_pkg::ST_K_RD: state_in = lgts_pkg::ST_K_CMP;
         lgts_pkg::ST_K_CMP: begin
            cmd.walk      = 1'b1;
            cmd.walk_last = j_last;
            if (stat.walk_hit || j_last) begin
               state_in = lgts_pkg::ST_ADD_RD;
            end else begin
               j_in     = j_ff + lgts_pkg::TCNT_W'(1);
               state_in = lgts_pkg::ST_K_RD;
            end
         end
         lgts_pkg::ST_ADD_RD: begin
            cmd.tok_wr = 1'b1;
            state_in   = lgts_pkg::ST_ADD_WR;
         end
         lgts_pkg::ST_ADD_WR: begin
            cmd.cnt_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = lgts_pkg::ST_F_RD;
         end
         lgts_pkg::ST_F_RD: state_in = lgts_pkg::ST_OUT;
         lgts_pkg::ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = lgts_pkg::ST_IDLE;
            end
         end
         default: state_in = lgts_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

### design/lgts_dp.sv
// Datapath of the topic sampler: count tables, token store, divider, weights.
`default_nettype none
module lgts_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [lgts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic [lgts_pkg::TCNT_W-1:0]        t_used,
   input  wire logic [lgts_pkg::NG_W-1:0]          num_genes,
   input  wire logic [lgts_pkg::Q_W-1:0]           alpha,
   input  wire logic [lgts_pkg::Q_W-1:0]           beta,
   input  wire lgts_pkg::lgts_cmd_type             cmd,
   output lgts_pkg::lgts_stat_type                 stat,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [lgts_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int CNT_W = lgts_pkg::CNT_W;
   localparam int TOPIC_W = lgts_pkg::TOPIC_W;

   // memories
   logic [CNT_W-1:0]   gene_mem   [2**lgts_pkg::GADDR_W];
   logic [CNT_W-1:0]   sample_mem [2**lgts_pkg::SADDR_W];
   logic [CNT_W-1:0]   total_mem  [lgts_pkg::MAX_TOPICS];
   logic [TOPIC_W-1:0] token_mem  [lgts_pkg::MAX_TOKENS];
   logic [lgts_pkg::W_W-1:0] scratch_mem [lgts_pkg::MAX_TOPICS];

   // latched request
   logic [lgts_pkg::TOKEN_W-1:0]  tok_ff;
   logic [lgts_pkg::GENE_W-1:0]   gene_ff;
   logic [lgts_pkg::SAMPLE_W-1:0] samp_idx_ff;
   logic [lgts_pkg::Q_W-1:0]      rnd_ff;
   logic [TOPIC_W-1:0]            cur_ff, cur_in;
   logic [lgts_pkg::GB_W-1:0]     gb_ff;

   logic [lgts_pkg::GADDR_W:0]    clr_ff;
   logic [TOPIC_W-1:0]            sel_topic;
   logic [lgts_pkg::GADDR_W-1:0]  g_addr;
   logic [lgts_pkg::SADDR_W-1:0]  s_addr;
   logic [TOPIC_W-1:0]            t_addr;
   logic [CNT_W-1:0]              gc_ff, sc_ff, tt_ff;
   logic [CNT_W-1:0]              gc_in, sc_in, tt_in;
   logic                          mem_we;
   logic [TOPIC_W-1:0]            tok_rd_ff;
   logic [lgts_pkg::W_W-1:0]      scr_rd_ff;

   // weight arithmetic
   logic [lgts_pkg::NUM_W-1:0]    num, samp_ff;
   logic [lgts_pkg::DEN_W-1:0]    den;
   logic [lgts_pkg::DVD_W-1:0]    rem_ff;
   logic [lgts_pkg::DSH_W-1:0]    dsh_ff;
   logic                          ge;
   logic [lgts_pkg::Q_W-1:0]      q_ff, ratio;
   logic                          sat_ff;
   logic [2*lgts_pkg::Q_W-1:0]    plo_ff, rlo_ff;
   logic [lgts_pkg::Q_W+6-1:0]    phi_ff;
   logic [lgts_pkg::W_W+6:0]      w_full;
   logic [lgts_pkg::W_W-1:0]      w48;
   logic [lgts_pkg::SUM_W-1:0]    sum_ff, run_ff, run_in;
   logic [lgts_pkg::SUM_W-1:0]    rhi_ff;
   logic [lgts_pkg::SUM_W:0]      r_ff;
   logic [TOPIC_W+lgts_pkg::Q_W+1-1:0] init_prod;
   logic                          hit;
   logic                          rsp_valid_ff;
   logic [lgts_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // addresses: clearing sweep or current gene/sample/topic
   assign sel_topic = cmd.sel_j ? cmd.j : cur_ff;
   always_comb begin
      if (cmd.clr) begin
         g_addr = clr_ff[lgts_pkg::GADDR_W-1:0];
         s_addr = clr_ff[lgts_pkg::SADDR_W-1:0];
         t_addr = clr_ff[TOPIC_W-1:0];
      end else begin
         g_addr = {gene_ff, sel_topic};
         s_addr = {samp_idx_ff, sel_topic};
         t_addr = sel_topic;
      end
   end

   // zeroing during the clearing sweep, else saturating increment or decrement of the read counts
   always_comb begin
      if (cmd.clr) begin
         gc_in = '0;
         sc_in = '0;
         tt_in = '0;
      end else if (cmd.cnt_inc) begin
         gc_in = (gc_ff == lgts_pkg::CNT_MAX) ? gc_ff : gc_ff + CNT_W'(1);
         sc_in = (sc_ff == lgts_pkg::CNT_MAX) ? sc_ff : sc_ff + CNT_W'(1);
         tt_in = (tt_ff == lgts_pkg::CNT_MAX) ? tt_ff : tt_ff + CNT_W'(1);
      end else begin
         gc_in = (gc_ff == '0) ? gc_ff : gc_ff - CNT_W'(1);
         sc_in = (sc_ff == '0) ? sc_ff : sc_ff - CNT_W'(1);
         tt_in = (tt_ff == '0) ? tt_ff : tt_ff - CNT_W'(1);
      end
   end
   assign mem_we = cmd.clr || cmd.cnt_wr;

   // count tables, read data registered every cycle
   always_ff @(posedge clock) begin
      if (mem_we) gene_mem[g_addr] <= gc_in;
      gc_ff <= gene_mem[g_addr];
   end
   always_ff @(posedge clock) begin
      if (mem_we) sample_mem[s_addr] <= sc_in;
      sc_ff <= sample_mem[s_addr];
   end
   always_ff @(posedge clock) begin
      if (mem_we) total_mem[t_addr] <= tt_in;
      tt_ff <= total_mem[t_addr];
   end

   // token topic store
   always_ff @(posedge clock) begin
      if (cmd.tok_wr) token_mem[tok_ff] <= cur_ff;
      tok_rd_ff <= token_mem[tok_ff];
   end

   // weight store
   always_ff @(posedge clock) begin
      if (cmd.acc) scratch_mem[cmd.j] <= w48;
      scr_rd_ff <= scratch_mem[cmd.j];
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr) clr_ff <= clr_ff + (lgts_pkg::GADDR_W+1)'(1);
   end
   assign stat.clr_last = (clr_ff[lgts_pkg::GADDR_W-1:0] == '1);

   // request latch and topic selection
   assign init_prod = rnd_ff * (lgts_pkg::Q_W+TOPIC_W+1)'(t_used);
   always_comb begin
      cur_in = cur_ff;
      if (cmd.load) cur_in = req_tdata[77:72];
      else if (cmd.init_topic) cur_in = init_prod[lgts_pkg::Q_W +: TOPIC_W];
      else if (cmd.tok_take) cur_in = tok_rd_ff;
      else if (cmd.walk && (hit || cmd.walk_last)) cur_in = cmd.j;
   end
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load) begin
         tok_ff      <= req_tdata[19:0];
         gene_ff     <= req_tdata[31:20];
         samp_idx_ff <= req_tdata[39:32];
         rnd_ff      <= req_tdata[71:40];
         gb_ff       <= lgts_pkg::GB_W'(num_genes) * lgts_pkg::GB_W'(beta);
      end
   end

   // operands of one topic's weight
   assign num = {1'b0, gc_ff, 16'b0} + lgts_pkg::NUM_W'(beta);
   always_comb begin
      den = lgts_pkg::DEN_W'({tt_ff, 16'b0}) + lgts_pkg::DEN_W'(gb_ff);
      if (den == '0) den = lgts_pkg::DEN_W'(1);
   end

   // restoring divider, one quotient bit a cycle, saturation check first
   assign ge = (lgts_pkg::DSH_W'(rem_ff) >= dsh_ff);
   always_ff @(posedge clock) begin
      if (cmd.w_start) begin
         rem_ff  <= {num, 16'b0};
         dsh_ff  <= {den, 32'b0};
         samp_ff <= {1'b0, sc_ff, 16'b0} + lgts_pkg::NUM_W'(alpha);
      end else if (cmd.div_step) begin
         dsh_ff <= dsh_ff >> 1;
         if (cmd.div_first) begin
            sat_ff <= ge;
         end else begin
            q_ff <= {q_ff[lgts_pkg::Q_W-2:0], ge};
            if (ge) rem_ff <= rem_ff - lgts_pkg::DVD_W'(dsh_ff);
         end
      end
   end
   assign ratio = sat_ff ? '1 : q_ff;

   // weight = ratio * samp >> 16, split in two registered products
   always_ff @(posedge clock) begin
      if (cmd.mul_lo) plo_ff <= (2*lgts_pkg::Q_W)'(ratio) * (2*lgts_pkg::Q_W)'(samp_ff[31:0]);
      if (cmd.mul_hi) phi_ff <= (lgts_pkg::Q_W+6)'(ratio) * (lgts_pkg::Q_W+6)'(samp_ff[37:32]);
   end
   assign w_full = (lgts_pkg::W_W+7)'(plo_ff[63:16]) + (lgts_pkg::W_W+7)'({phi_ff, 16'b0});
   assign w48 = (|w_full[lgts_pkg::W_W+6:lgts_pkg::W_W]) ? '1 : w_full[lgts_pkg::W_W-1:0];

   // weight sum, threshold and running sum
   assign run_in = run_ff + lgts_pkg::SUM_W'(scr_rd_ff);
   assign hit = ((lgts_pkg::SUM_W+1)'(run_in) >= r_ff);
   assign stat.walk_hit = hit;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff <= '0;
         run_ff <= '0;
      end else begin
         if (cmd.acc) sum_ff <= sum_ff + lgts_pkg::SUM_W'(w48);
         if (cmd.walk) run_ff <= run_in;
      end
      if (cmd.r_mul) begin
         rhi_ff <= lgts_pkg::SUM_W'(sum_ff[lgts_pkg::SUM_W-1:32]) * lgts_pkg::SUM_W'(rnd_ff);
         rlo_ff <= (2*lgts_pkg::Q_W)'(sum_ff[31:0]) * (2*lgts_pkg::Q_W)'(rnd_ff);
      end
      if (cmd.r_fin)
         r_ff <= (lgts_pkg::SUM_W+1)'(rhi_ff) + (lgts_pkg::SUM_W+1)'(rlo_ff[63:32]);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) rsp_data_ff <= {7'b0, tt_ff, sc_ff, gc_ff, cur_ff, tok_ff};
   end
   assign stat.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

### design/lda_gibbs_topic_sampler_core.sv
// Top level of the LDA collapsed Gibbs topic sampler.
//
//   channel | direction | payload
//   req     | in        | tuser: func; tdata: token, gene, sample, random, query topic
//   rsp     | out       | tdata: token, topic, gene count, sample count, topic total
//   csr     | in        | write enable, register index, 32-bit value
//
// For each of T topics, resample does count read, operand load, one-bit-a-cycle
// division, two multiplies and accumulate; it then walks the stored weights topic
// by topic.
// After reset a clearing sweep zeroes the count tables; no word
// is accepted during it. A stalled result register holds; the next word is still
// taken while it waits.
`default_nettype none
module lda_gibbs_topic_sampler_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,   // func
   input  wire logic [79:0]  req_tdata,   // token_index, gene_index, sample_index,
                                          // random_word, query_topic, zero fill
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,   // token_out, topic, gene_count,
                                          // sample_count, topic_total, zero fill
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);

   logic [6:0]  nt_ff;
   logic [12:0] ng_ff;
   logic [31:0] alpha_ff, beta_ff;
   logic [lgts_pkg::TCNT_W-1:0] t_used;
   lgts_pkg::lgts_cmd_type  cmd;
   lgts_pkg::lgts_stat_type stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nt_ff    <= 7'd1;
         ng_ff    <= 13'd1;
         alpha_ff <= 32'd65536;
         beta_ff  <= 32'd655;
      end else if (csr_we) begin
         unique case (csr_addr)
            lgts_pkg::REG_NUM_TOPICS: nt_ff    <= csr_wdata[6:0];
            lgts_pkg::REG_NUM_GENES:  ng_ff    <= csr_wdata[12:0];
            lgts_pkg::REG_ALPHA:      alpha_ff <= csr_wdata;
            lgts_pkg::REG_BETA:       beta_ff  <= csr_wdata;
         endcase
      end
   end

   // topics in use, clamped to one..MAX_TOPICS
   always_comb begin
      if (nt_ff == '0) t_used = lgts_pkg::TCNT_W'(1);
      else if (nt_ff > 7'(lgts_pkg::MAX_TOPICS))
         t_used = lgts_pkg::TCNT_W'(lgts_pkg::MAX_TOPICS);
      else t_used = lgts_pkg::TCNT_W'(nt_ff);
   end

   lgts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .t_used     (t_used),
      .stat       (stat),
      .cmd        (cmd)
   );

   lgts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .t_used     (t_used),
      .num_genes  (ng_ff),
      .alpha      (alpha_ff),
      .beta       (beta_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### design/lgts_chk.sv
// Port-level checks of the topic sampler and their binding to the top level.
`default_nettype none
module lgts_chk (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [1:0] req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready
);

   // a held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a word that does work makes the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != lgts_pkg::FUNC_NONE) |=> !req_tready)
      else $error("word accepted while previous one still in work");

   // the clearing sweep blocks input right after reset
   a_clear: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input open during clearing sweep");

   // no result straight out of reset
   a_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind lda_gibbs_topic_sampler_core lgts_chk u_lgts_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire
